// ----- hw/rtl/hfn_pkg.sv -----
// Shared types and constants for the height field normal engine.
// Used by heightfield_normal_engine; no dependencies.
package hfn_pkg;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_SQUARE = 6'b001000,
      ST_NORM   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   localparam logic [1:0] CSR_GRID_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_GRID_DEPTH    = 2'd1;
   localparam logic [1:0] CSR_VERTICAL_TERM = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [14:0] UNIT_Q14 = 15'd16384;
   localparam logic [3:0]  TOP_BIT  = 4'd14;

endpackage

// ----- hw/rtl/hfn_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module hfn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/heightfield_normal_engine.sv -----
// Height field store with central-difference unit normal queries; needs hfn_pkg, hfn_ram.
// A write beat leaves the engine idle. A query reads its cells, squares three terms,
// runs 45 normalizer steps (none when the squares sum to zero) and loads the output.
// The next beat is taken after that load; until then req_stall stays high, and the
// load waits while an earlier result is stalled. Reset is synchronous; a clearing pass over
// all MAX_GRID_WIDTH * MAX_GRID_DEPTH cells then zeroes the store with req_stall high.
module heightfield_normal_engine #(
   parameter int MAX_GRID_WIDTH = 256,
   parameter int MAX_GRID_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [7:0]         req_cell_x,
   input  logic [7:0]         req_cell_z,
   input  logic signed [15:0] req_height_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_normal_x,
   output logic [14:0]        rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic signed [15:0] rsp_height_out,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int DEPTH = MAX_GRID_WIDTH * MAX_GRID_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_GRID_WIDTH + 1);
   localparam int ZW    = $clog2(MAX_GRID_DEPTH + 1);

   hfn_pkg::state_type state_ff, state_in;

   logic [8:0]  grid_width_ff, grid_depth_ff;
   logic [15:0] vterm_ff;

   logic [AW-1:0] clr_ff, clr_in;
   logic [XW-1:0] x_ff, x_in;
   logic [ZW-1:0] z_ff, z_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic signed [15:0] h_ff [5];
   logic [31:0]   sq_ff [3];
   logic [33:0]   s_ff, s_in;
   logic [1:0]    comp_ff, comp_in;
   logic [3:0]    bit_ff, bit_in;
   logic [14:0]   q_ff, q_in;
   logic [14:0]   qres_ff [3];
   logic signed [67:0] p_ff, p_in, r_ff, r_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_nx_ff, rsp_nz_ff, rsp_h_ff;
   logic [14:0]        rsp_ny_ff;

   logic [XW-1:0] gw, qx, xl, xr, xs;
   logic [ZW-1:0] gd, qz, zu, zd, zs;
   logic          req_accept, wr_in_grid, rsp_load;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr, req_addr;
   logic [15:0]   ram_wr_data, ram_rd_data;
   logic signed [16:0] diff_x, diff_z;
   logic [15:0]   mag_x, mag_z, mul_a;
   logic [33:0]   s_sum;
   logic signed [67:0] target, p_try, s_wide;
   logic          take;
   logic [14:0]   q_final;

   always_comb begin
      if (grid_width_ff < 9'd2) begin
         gw = XW'(2);
      end else if (32'(grid_width_ff) > MAX_GRID_WIDTH) begin
         gw = XW'(MAX_GRID_WIDTH);
      end else begin
         gw = XW'(grid_width_ff);
      end
      if (grid_depth_ff < 9'd2) begin
         gd = ZW'(2);
      end else if (32'(grid_depth_ff) > MAX_GRID_DEPTH) begin
         gd = ZW'(MAX_GRID_DEPTH);
      end else begin
         gd = ZW'(grid_depth_ff);
      end
   end

   assign req_stall  = (state_ff != hfn_pkg::ST_IDLE);
   assign req_accept = req_valid && (state_ff == hfn_pkg::ST_IDLE);
   assign wr_in_grid = (32'(req_cell_x) < 32'(gw)) && (32'(req_cell_z) < 32'(gd));
   assign req_addr   = AW'(32'(req_cell_z) * MAX_GRID_WIDTH + 32'(req_cell_x));
   assign qx = (32'(req_cell_x) > 32'(gw) - 1) ? gw - XW'(1) : XW'(req_cell_x);
   assign qz = (32'(req_cell_z) > 32'(gd) - 1) ? gd - ZW'(1) : ZW'(req_cell_z);

   assign xl = (x_ff != '0) ? x_ff - XW'(1) : '0;
   assign xr = (32'(x_ff) + 1 < 32'(gw)) ? x_ff + XW'(1) : gw - XW'(1);
   assign zu = (z_ff != '0) ? z_ff - ZW'(1) : '0;
   assign zd = (32'(z_ff) + 1 < 32'(gd)) ? z_ff + ZW'(1) : gd - ZW'(1);

   always_comb begin
      case (cnt_ff)
         3'd1:    begin xs = xl;   zs = z_ff; end
         3'd2:    begin xs = xr;   zs = z_ff; end
         3'd3:    begin xs = x_ff; zs = zu;   end
         3'd4:    begin xs = x_ff; zs = zd;   end
         default: begin xs = x_ff; zs = z_ff; end
      endcase
   end

   assign ram_rd_addr = AW'(32'(zs) * MAX_GRID_WIDTH + 32'(xs));

   always_comb begin
      if (state_ff == hfn_pkg::ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = req_accept && (req_command == hfn_pkg::CMD_WRITE) && wr_in_grid;
         ram_wr_addr = req_addr;
         ram_wr_data = req_height_in;
      end
   end

   hfn_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign diff_x = 17'(h_ff[1]) - 17'(h_ff[2]);
   assign diff_z = 17'(h_ff[3]) - 17'(h_ff[4]);
   assign mag_x  = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
   assign mag_z  = diff_z[16] ? 16'(-diff_z) : diff_z[15:0];

   always_comb begin
      case (cnt_ff)
         3'd0:    mul_a = mag_x;
         3'd1:    mul_a = vterm_ff;
         default: mul_a = mag_z;
      endcase
   end

   assign s_sum  = 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]);
   assign s_wide = signed'(68'(s_ff));
   assign target = signed'({6'd0, sq_ff[comp_ff], 30'd0});
   assign p_try  = p_ff + (r_ff <<< (6'(bit_ff) + 6'd2))
                 + (s_wide <<< (6'({bit_ff, 1'b0}) + 6'd2));
   assign take    = !q_ff[14] && (p_try <= target);
   assign q_final = take ? (q_ff | (15'd1 << bit_ff)) : q_ff;
   assign rsp_load = (state_ff == hfn_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      x_in     = x_ff;
      z_in     = z_ff;
      cnt_in   = cnt_ff;
      s_in     = s_ff;
      comp_in  = comp_ff;
      bit_in   = bit_ff;
      q_in     = q_ff;
      p_in     = p_ff;
      r_in     = r_ff;
      case (state_ff)
         hfn_pkg::ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = hfn_pkg::ST_IDLE;
            end
         end
         hfn_pkg::ST_IDLE: begin
            if (req_accept && (req_command == hfn_pkg::CMD_QUERY)) begin
               x_in     = qx;
               z_in     = qz;
               cnt_in   = '0;
               state_in = hfn_pkg::ST_READ;
            end
         end
         hfn_pkg::ST_READ: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               cnt_in   = '0;
               state_in = hfn_pkg::ST_SQUARE;
            end
         end
         hfn_pkg::ST_SQUARE: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               s_in    = s_sum;
               comp_in = '0;
               bit_in  = hfn_pkg::TOP_BIT;
               q_in    = '0;
               p_in    = signed'(68'(s_sum));
               r_in    = -signed'(68'(s_sum));
               state_in = (s_sum == '0) ? hfn_pkg::ST_DONE : hfn_pkg::ST_NORM;
            end
         end
         hfn_pkg::ST_NORM: begin
            if (take) begin
               q_in = q_final;
               p_in = p_try;
               r_in = r_ff + (s_wide <<< (6'(bit_ff) + 6'd1));
            end
            bit_in = bit_ff - 4'd1;
            if (bit_ff == '0) begin
               comp_in = comp_ff + 2'd1;
               bit_in  = hfn_pkg::TOP_BIT;
               q_in    = '0;
               p_in    = s_wide;
               r_in    = -s_wide;
               if (comp_ff == 2'd2) begin
                  state_in = hfn_pkg::ST_DONE;
               end
            end
         end
         hfn_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = hfn_pkg::ST_IDLE;
            end
         end
         default: state_in = hfn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hfn_pkg::ST_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         grid_width_ff <= 9'd256;
         grid_depth_ff <= 9'd256;
         vterm_ff      <= 16'd256;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               hfn_pkg::CSR_GRID_WIDTH:    grid_width_ff <= csr_wdata[8:0];
               hfn_pkg::CSR_GRID_DEPTH:    grid_depth_ff <= csr_wdata[8:0];
               hfn_pkg::CSR_VERTICAL_TERM: vterm_ff      <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      z_ff    <= z_in;
      cnt_ff  <= cnt_in;
      s_ff    <= s_in;
      comp_ff <= comp_in;
      bit_ff  <= bit_in;
      q_ff    <= q_in;
      p_ff    <= p_in;
      r_ff    <= r_in;
      if ((state_ff == hfn_pkg::ST_READ) && (cnt_ff != 3'd0)) begin
         h_ff[3'(cnt_ff - 3'd1)] <= signed'(ram_rd_data);
      end
      if ((state_ff == hfn_pkg::ST_SQUARE) && (cnt_ff != 3'd3)) begin
         sq_ff[2'(cnt_ff)] <= 32'(mul_a) * 32'(mul_a);
      end
      if ((state_ff == hfn_pkg::ST_SQUARE) && (cnt_ff == 3'd3) && (s_sum == '0)) begin
         qres_ff[0] <= '0;
         qres_ff[1] <= '0;
         qres_ff[2] <= '0;
      end
      if ((state_ff == hfn_pkg::ST_NORM) && (bit_ff == '0)) begin
         qres_ff[comp_ff] <= q_final;
      end
      if (rsp_load) begin
         rsp_nx_ff <= diff_x[16] ? -signed'(16'(qres_ff[0])) : signed'(16'(qres_ff[0]));
         rsp_ny_ff <= qres_ff[1];
         rsp_nz_ff <= diff_z[16] ? -signed'(16'(qres_ff[2])) : signed'(16'(qres_ff[2]));
         rsp_h_ff  <= h_ff[0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = rsp_nx_ff;
   assign rsp_normal_y   = rsp_ny_ff;
   assign rsp_normal_z   = rsp_nz_ff;
   assign rsp_height_out = rsp_h_ff;

   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hfn_pkg::ST_CLEAR) |-> (req_stall && !rsp_valid))
      else $error("input accepted or result shown during clearing pass");

   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hfn_pkg::ST_NORM) |-> (q_ff <= hfn_pkg::UNIT_Q14))
      else $error("normalizer magnitude above unit");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == hfn_pkg::ST_DONE))
      else $error("result raised outside the done state");

   a_no_write_in_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hfn_pkg::ST_READ || state_ff == hfn_pkg::ST_NORM) |-> !ram_wr_en)
      else $error("store written while a query is in flight");

endmodule
